FILE: rtl/secded_72_64_packet_decoder_unit_assert.svh
// assertion macros shared by the secded decoder checker
// no dependencies; included by bare file name
`ifndef SECDED_72_64_PACKET_DECODER_UNIT_ASSERT_SVH
`define SECDED_72_64_PACKET_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SECDED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SECDED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/secded_pkg.sv
// types and constants of the secded (72,64) packet decoder
// no dependencies
package secded_pkg;

  localparam int CODE_W  = 72;
  localparam int POS_MAX = 71;
  localparam int SYN_W   = 7;
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 7;
  localparam int CNT_MAX = 127;

  typedef enum logic [1:0] {
    ST_CLEAN  = 2'd0,
    ST_CORR   = 2'd1,
    ST_UNCORR = 2'd2
  } status_t;

  // per-word decode result handed to the packet tracker
  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
  } dec_t;

endpackage

FILE: rtl/secded_decode.sv
// syndrome, single-bit correction and data extraction for one codeword
// depends on secded_pkg
module secded_decode (
  input  logic [secded_pkg::CODE_W-1:0] code,
  output secded_pkg::dec_t              dec
);

  logic [secded_pkg::SYN_W-1:0]  syn;
  logic                          par;
  logic                          fixable;
  logic [secded_pkg::POS_MAX-1:0] flip;
  logic [secded_pkg::POS_MAX-1:0] fixed;
  logic [secded_pkg::DATA_W-1:0] data;
  secded_pkg::status_t           status;

  // syndrome is the xor of the positions of all set bits in positions 1..71, not the parity bit
  always_comb begin
    syn = '0;
    for (int p = 1; p <= secded_pkg::POS_MAX; p++) begin
      if (code[p-1]) begin
        syn = syn ^ secded_pkg::SYN_W'(p);
      end
    end
  end

  assign par = ^code;

  always_comb begin
    fixable = 1'b0;
    if (syn != '0) begin
      if (!par || syn > secded_pkg::SYN_W'(secded_pkg::POS_MAX)) begin
        status = secded_pkg::ST_UNCORR;
      end else begin
        status  = secded_pkg::ST_CORR;
        fixable = 1'b1;
      end
    end else begin
      status = par ? secded_pkg::ST_CORR : secded_pkg::ST_CLEAN;
    end
  end

  assign flip  = fixable ? (secded_pkg::POS_MAX'(1) << (syn - secded_pkg::SYN_W'(1)))
                         : '0;
  assign fixed = code[secded_pkg::POS_MAX-1:0] ^ flip;

  // data sits at every position that is not a power of two
  always_comb begin
    int k;
    k    = 0;
    data = '0;
    for (int p = 1; p <= secded_pkg::POS_MAX; p++) begin
      if ((p & (p - 1)) != 0) begin
        data[6'(k)] = fixed[p-1];
        k = k + 1;
      end
    end
  end

  assign dec.data   = data;
  assign dec.status = status;

endmodule

FILE: rtl/secded_track.sv
// per-packet corrected count and failed flag, plus the result register
// depends on secded_pkg
module secded_track #(
  parameter int MAX_WORDS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  secded_pkg::dec_t                     dec,
  input  logic                                 last,
  output logic [secded_pkg::DATA_W-1:0]        data_word,
  output logic [1:0]                           word_status,
  output logic                                 packet_last,
  output logic                                 packet_failed,
  output logic [secded_pkg::CNT_W-1:0]         corrected_total
);

  localparam int CAP = (MAX_WORDS < secded_pkg::CNT_MAX) ? MAX_WORDS : secded_pkg::CNT_MAX;

  logic [secded_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_upd;
  logic                          failed_r, failed_nxt, failed_upd;
  logic [secded_pkg::DATA_W-1:0] data_r;
  logic [1:0]                    status_r;
  logic                          last_r, pfail_r;
  logic [secded_pkg::CNT_W-1:0]  total_r;

  always_comb begin
    cnt_upd    = cnt_r;
    failed_upd = failed_r;
    if (!failed_r) begin
      if (dec.status == secded_pkg::ST_UNCORR) begin
        failed_upd = 1'b1;
      end else if (dec.status == secded_pkg::ST_CORR &&
                   cnt_r < secded_pkg::CNT_W'(CAP)) begin
        cnt_upd = cnt_r + secded_pkg::CNT_W'(1);
      end
    end
    // packet state clears after the last word
    cnt_nxt    = last ? '0 : cnt_upd;
    failed_nxt = last ? 1'b0 : failed_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      failed_r <= 1'b0;
    end else if (load) begin
      cnt_r    <= cnt_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= failed_upd ? '0 : dec.data;
      status_r <= dec.status;
      last_r   <= last;
      pfail_r  <= failed_upd;
      total_r  <= cnt_upd;
    end
  end

  assign data_word       = data_r;
  assign word_status     = status_r;
  assign packet_last     = last_r;
  assign packet_failed   = pfail_r;
  assign corrected_total = total_r;

endmodule

FILE: rtl/secded_72_64_packet_decoder_unit.sv
// top level of the secded (72,64) packet decoder
// depends on secded_pkg, secded_decode, secded_track
//
// Decodes one 72-bit extended Hamming codeword per item: positions 1..64 on
// in_code_low, 65..71 on in_code_high[6:0], overall parity on in_code_high[7].
// Single errors (including an error in the overall parity bit alone) are
// corrected and reported as status 1; double errors or a syndrome above 71 are
// status 2 and mark the packet failed, after which data words read as zero
// until the packet's last word. The per-packet corrected count saturates at
// the smaller of MAX_WORDS and 127 and, with the failed flag, clears after the
// item flagged in_word_last. The accepted item sits in the input register,
// and the syndrome xor tree, correction and bookkeeping load the result
// register, which drives out_valid, once it is empty or being drained. One
// item is accepted every cycle as long as the result side takes results;
// in_ready drops only when both the input register and the result
// register hold items and out_ready is low.
module secded_72_64_packet_decoder_unit #(
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // codeword item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_code_low,
  input  logic [7:0]  in_code_high,
  input  logic        in_word_last,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data_word,
  output logic [1:0]  out_word_status,
  output logic        out_packet_last,
  output logic        out_packet_failed,
  output logic [6:0]  out_corrected_total
);

  // input register stage
  logic                          in_valid_r;
  logic [secded_pkg::CODE_W-1:0] code_r;
  logic                          last_r;
  // result register stage
  logic                          out_valid_r;
  logic                          load_out;
  secded_pkg::dec_t              dec;

  // move an item forward when the result register is empty or being drained
  assign load_out = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (load_out) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= {in_code_high, in_code_low};
      last_r <= in_word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  secded_decode u_decode (
    .code (code_r),
    .dec  (dec)
  );

  // packet bookkeeping is updated in item order as each word enters the result register
  secded_track #(
    .MAX_WORDS (MAX_WORDS)
  ) u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load_out),
    .dec             (dec),
    .last            (last_r),
    .data_word       (out_data_word),
    .word_status     (out_word_status),
    .packet_last     (out_packet_last),
    .packet_failed   (out_packet_failed),
    .corrected_total (out_corrected_total)
  );

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/secded_checker.sv
// port-level checks for the secded packet decoder, bound to the top level
// depends on secded_pkg and secded_72_64_packet_decoder_unit_assert.svh
`include "secded_72_64_packet_decoder_unit_assert.svh"

module secded_checker #(
  parameter int MAX_WORDS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data_word,
  input logic [1:0]  out_word_status,
  input logic        out_packet_failed,
  input logic [6:0]  out_corrected_total
);

  localparam int CAP = (MAX_WORDS < 127) ? MAX_WORDS : 127;

  // stalled result holds
  `SECDED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data_word) && $stable(out_word_status), "stalled result changed")

  // a failed packet never shows data
  `SECDED_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_packet_failed,
    out_data_word == 64'd0, "data shown on failed packet")

  // an uncorrectable word always marks the packet failed
  `SECDED_ASSERT_NOW(a_uncorr_fails, clk, rst_n,
    out_valid && out_word_status == secded_pkg::ST_UNCORR,
    out_packet_failed, "uncorrectable word without packet failure")

  // count stays within its cap
  `SECDED_ASSERT_NOW(a_cnt_cap, clk, rst_n, out_valid,
    out_corrected_total <= 7'(CAP), "corrected count above cap")

endmodule

bind secded_72_64_packet_decoder_unit secded_checker #(.MAX_WORDS(MAX_WORDS)) u_checker (.*);
